// ===== rtl/core/psc_pkg.sv =====
// shared types and constants of the speed command conditioner
package psc_pkg;

	localparam int ADC_W = 12;
	localparam int HZ_W = 20;
	localparam int ROM_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [ADC_W-1:0] ADC_MAX = 12'd4095;
	localparam logic [HZ_W-1:0] LOW_SPEED_HZ = 20'd3000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_BAND = 3'd0,
		CFG_FULL_BAND = 3'd1,
		CFG_MAX_SPEED = 3'd2,
		CFG_HYSTERESIS = 3'd3,
		CFG_INVERT_POT = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_PREFILL = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RING_RD,
		ST_RING_UPD,
		ST_MEAN,
		ST_BAND,
		ST_T_WAIT,
		ST_ROM,
		ST_MUL,
		ST_DECIDE,
		ST_DONE
	} psc_state_t;

	typedef struct packed {
		logic prefill;
		logic rd;
		logic upd;
	} ring_ctl_t;

endpackage

// ===== rtl/core/psc_ring.sv =====
// sample ring with running sum, prefill by fill value and per-entry valid bits
module psc_ring import psc_pkg::*; #(
	parameter int FILTER_DEPTH = 16,
	parameter int SUM_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_ctl_t        ctl,
	input  logic [ADC_W-1:0] data,
	output logic [SUM_W-1:0] sum
);

	localparam int IDX_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_DEPTH - 1);
	localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(FILTER_DEPTH);

	logic [ADC_W-1:0] mem [FILTER_DEPTH];
	logic [ADC_W-1:0] rd_q;
	logic [FILTER_DEPTH-1:0] valid_q;
	logic vrd_q;
	logic [ADC_W-1:0] fill_q;
	logic [IDX_W-1:0] widx_q;
	logic [SUM_W-1:0] sum_q;

	logic [ADC_W-1:0] old_val;
	logic [SUM_W:0] sum_next;
	logic [SUM_W-1:0] fill_sum;

	// an entry not written since the last prefill reads as the fill value
	assign old_val = vrd_q ? rd_q : fill_q;
	assign sum_next = {1'b0, sum_q} + (SUM_W+1)'(data) - (SUM_W+1)'(old_val);
	assign fill_sum = SUM_W'(data) * DEPTH_V;
	assign sum = sum_q;

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			mem[widx_q] <= data;
		end
		if (ctl.rd) begin
			rd_q <= mem[widx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vrd_q <= 1'b0;
			fill_q <= '0;
			widx_q <= '0;
			sum_q <= '0;
		end else begin
			if (ctl.prefill) begin
				valid_q <= '0;
				fill_q <= data;
				sum_q <= fill_sum;
			end else if (ctl.upd) begin
				valid_q[widx_q] <= 1'b1;
				sum_q <= sum_next[SUM_W-1:0];
				widx_q <= (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
			end
			if (ctl.rd) begin
				vrd_q <= valid_q[widx_q];
			end
		end
	end

endmodule

// ===== rtl/core/psc_div.sv =====
// restoring divider, one quotient bit per cycle
module psc_div import psc_pkg::*; #(
	parameter int DW = 22,
	parameter int VW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [VW:0] shifted;
	logic [VW+1:0] diff;
	logic ge;

	assign shifted = {rem_q[VW-1:0], quo_q[DW-1]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge = !diff[VW+1];
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW:0] : shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/psc_curve_rom.sv =====
// exponential curve table (e^(kt)-1)/(e^k-1) in Q0.16, built at elaboration
module psc_curve_rom import psc_pkg::*; #(
	parameter int CURVE_K_TENTHS = 45,
	parameter int CURVE_ADDR_BITS = 10
) (
	input  logic                       clk,
	input  logic [CURVE_ADDR_BITS-1:0] addr,
	output logic [ROM_W-1:0]           data
);

	localparam int N = 1 << CURVE_ADDR_BITS;
	localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
	localparam logic [63:0] ARG_DIV = 64'(10 * N);

	// floor(a * b / 2^32)
	function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[95:32];
	endfunction

	// Q32 taylor series of exp
	function automatic logic [63:0] exp_q32(input logic [63:0] x);
		logic [63:0] acc;
		logic [63:0] term;
		acc = ONE_Q32;
		term = ONE_Q32;
		for (int n = 1; n < 80; n++) begin
			term = q32_mul(term, x) / 64'(n);
			if (term == 64'd0) begin
				break;
			end
			acc = acc + term;
		end
		return acc;
	endfunction

	function automatic logic [63:0] curve_arg(input logic [63:0] i);
		return ((64'(CURVE_K_TENTHS) * i) << 32) / ARG_DIV;
	endfunction

	localparam logic [63:0] DEN_RAW = exp_q32(curve_arg(64'(N))) - ONE_Q32;
	localparam logic [63:0] DEN = (DEN_RAW == 64'd0) ? 64'd1 : DEN_RAW;

	function automatic logic [ROM_W-1:0] curve_entry(input int unsigned idx);
		logic [63:0] num;
		logic [63:0] v;
		num = exp_q32(curve_arg(64'(idx))) - ONE_Q32;
		v = ((num << 16) + DEN / 64'd2) / DEN;
		if (v > 64'd65535) begin
			v = 64'd65535;
		end
		return v[ROM_W-1:0];
	endfunction

	logic [ROM_W-1:0] rom_w [N];
	logic [ROM_W-1:0] data_q;

	for (genvar g = 0; g < N; g++) begin : g_rom
		localparam logic [ROM_W-1:0] V = curve_entry(g);
		assign rom_w[g] = V;
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

	assign data = data_q;

endmodule

// ===== rtl/core/pot_speed_command_conditioner.sv =====
// top level: sequencer, configuration, hysteresis and output register
//
// Turns 12-bit potentiometer samples into a held speed command in Hz.
// Input channel (in_valid/in_ready) carries operation and sample; a prefill
// beat loads every ring entry with the sample and gives no result.
// A normal sample beat gives exactly one speed_hz beat on out_valid/out_ready.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; indexes past the last register are dropped.
// The ring mean comes from a reciprocal multiply; one restoring divider
// forms the curve index, one bit per cycle. A mean in the zero band or in
// the full band gives its result sooner, since both skip the division and
// the curve lookup. in_ready is high only while idle, which the sequencer
// enters as the result is loaded into the output register.
// A finished result sits in the output register while the next item is taken;
// if the receiver stalls, the sequencer waits in its last step until the
// output register frees. Reset clears the ring to zero, the held speed to
// zero and the registers to their defaults; no clearing pass is needed.
module pot_speed_command_conditioner import psc_pkg::*; #(
	parameter int FILTER_DEPTH = 16,
	parameter int CURVE_K_TENTHS = 45,
	parameter int CURVE_ADDR_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [ADC_W-1:0]     sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HZ_W-1:0]      speed_hz,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HZ_W-1:0]      cfg_data
);

	localparam int AB = CURVE_ADDR_BITS;
	localparam int DEPTH_LOG = $clog2(FILTER_DEPTH);
	localparam int SUM_W = ADC_W + DEPTH_LOG;
	localparam int DIV_W = ADC_W + AB;
	// floor(sum / depth) as floor(sum * RECIP / 2^RECIP_SH), exact for any sum
	localparam int RECIP_SH = SUM_W + DEPTH_LOG;
	localparam int MP_W = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(((64'd1 << RECIP_SH)
		+ 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));

	psc_state_t state_q, state_d;

	logic [ADC_W-1:0] zero_q;
	logic [ADC_W-1:0] full_q;
	logic [HZ_W-1:0] max_q;
	logic [HZ_W-1:0] hyst_q;
	logic invert_q;

	logic [ADC_W-1:0] smp_q;
	logic [ADC_W-1:0] mean_q;
	logic [AB-1:0] t_q;
	logic [HZ_W-1:0] hz_q;
	logic upd_q;
	logic [HZ_W-1:0] held_q;
	logic out_valid_q;
	logic [HZ_W-1:0] speed_q;

	ring_ctl_t ring_ctl;
	logic [ADC_W-1:0] ring_data;
	logic [SUM_W-1:0] ring_sum;

	logic div_start;
	logic div_done;
	logic [DIV_W-1:0] div_dividend;
	logic [ADC_W-1:0] div_divisor;
	logic [DIV_W-1:0] div_quo;

	logic [ROM_W-1:0] rom_data;
	logic [ROM_W+HZ_W-1:0] prod;
	logic [MP_W-1:0] mean_prod;

	logic in_zero;
	logic in_full;
	logic [ADC_W-1:0] mean_raw;
	logic [HZ_W-1:0] delta;
	logic [HZ_W-1:0] top;
	logic upd_d;
	logic out_load;
	logic [HZ_W-1:0] new_held;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign speed_hz = speed_q;

	assign in_zero = mean_q <= zero_q;
	assign in_full = mean_q >= full_q;
	assign mean_prod = MP_W'(ring_sum) * MP_W'(RECIP);
	assign mean_raw = mean_prod[RECIP_SH +: ADC_W];
	assign prod = (ROM_W+HZ_W)'(rom_data) * (ROM_W+HZ_W)'(max_q);
	assign delta = (hz_q > held_q) ? hz_q - held_q : held_q - hz_q;
	assign top = (max_q > hyst_q) ? max_q - hyst_q : '0;
	assign upd_d = (delta >= hyst_q) || (hz_q < LOW_SPEED_HZ) || (hz_q >= top);
	assign new_held = upd_q ? hz_q : held_q;
	assign ring_data = (state_q == ST_IDLE) ? sample : smp_q;

	assign div_dividend = DIV_W'(mean_q - zero_q) << AB;
	assign div_divisor = full_q - zero_q;

	psc_ring #(
		.FILTER_DEPTH(FILTER_DEPTH),
		.SUM_W(SUM_W)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ring_ctl),
		.data(ring_data),
		.sum(ring_sum)
	);

	psc_div #(
		.DW(DIV_W),
		.VW(ADC_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo)
	);

	psc_curve_rom #(
		.CURVE_K_TENTHS(CURVE_K_TENTHS),
		.CURVE_ADDR_BITS(CURVE_ADDR_BITS)
	) u_rom (
		.clk(clk),
		.addr(t_q),
		.data(rom_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && operation == OP_SAMPLE) begin
					state_d = ST_RING_RD;
				end
			end
			ST_RING_RD: state_d = ST_RING_UPD;
			ST_RING_UPD: state_d = ST_MEAN;
			ST_MEAN: state_d = ST_BAND;
			ST_BAND: begin
				if (in_zero) begin
					state_d = ST_DONE;
				end else if (in_full) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_T_WAIT;
				end
			end
			ST_T_WAIT: begin
				if (div_done) begin
					state_d = ST_ROM;
				end
			end
			ST_ROM: state_d = ST_MUL;
			ST_MUL: state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ring_ctl = '0;
		div_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ring_ctl.prefill = in_valid && operation == OP_PREFILL;
			end
			ST_RING_RD: ring_ctl.rd = 1'b1;
			ST_RING_UPD: ring_ctl.upd = 1'b1;
			ST_BAND: div_start = !in_zero && !in_full;
			ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 12'd50;
			full_q <= 12'd4000;
			max_q <= 20'd50000;
			hyst_q <= 20'd100;
			invert_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ZERO_BAND: zero_q <= cfg_data[ADC_W-1:0];
				CFG_FULL_BAND: full_q <= cfg_data[ADC_W-1:0];
				CFG_MAX_SPEED: max_q <= cfg_data;
				CFG_HYSTERESIS: hyst_q <= cfg_data;
				CFG_INVERT_POT: invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: smp_q <= sample;
			ST_MEAN: mean_q <= invert_q ? ADC_MAX - mean_raw : mean_raw;
			ST_BAND: begin
				// zero band forces the output to zero, past the hysteresis rule
				if (in_zero) begin
					hz_q <= '0;
					upd_q <= 1'b1;
				end else if (in_full) begin
					hz_q <= max_q;
				end
			end
			ST_T_WAIT: begin
				if (div_done) begin
					t_q <= (div_quo[DIV_W-1:AB] != '0) ? '1 : div_quo[AB-1:0];
				end
			end
			ST_MUL: hz_q <= prod[ROM_W+HZ_W-1:ROM_W];
			ST_DECIDE: upd_q <= upd_d;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				held_q <= new_held;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			speed_q <= new_held;
		end
	end

endmodule
